### rtl/rvm_pkg.sv
// ----------------------------------------------------------------------------
// rvm_pkg
// Shared constants, codes, item types and helper functions of the
// register-memory VM execute unit.
// ----------------------------------------------------------------------------
package rvm_pkg;

   localparam int MEM_BYTES = 16384;
   localparam int NUM_REGS  = 16;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int REG_AW    = $clog2(NUM_REGS);

   localparam logic [REG_AW-1:0] REG_IP = REG_AW'(5);
   localparam logic [REG_AW-1:0] REG_CC = REG_AW'(8);
   localparam logic [REG_AW-1:0] REG_AC = REG_AW'(9);

   localparam logic [31:0] CC_ZERO = 32'h4000_0000;
   localparam logic [31:0] CC_NEG  = 32'h8000_0000;

   // Opcodes.
   localparam logic [7:0] OP_MOV  = 8'h00;
   localparam logic [7:0] OP_ADD  = 8'h01;
   localparam logic [7:0] OP_SUB  = 8'h02;
   localparam logic [7:0] OP_SWAP = 8'h03;
   localparam logic [7:0] OP_MUL  = 8'h04;
   localparam logic [7:0] OP_DIV  = 8'h05;
   localparam logic [7:0] OP_CMP  = 8'h06;
   localparam logic [7:0] OP_SHL  = 8'h07;
   localparam logic [7:0] OP_SHR  = 8'h08;
   localparam logic [7:0] OP_AND  = 8'h09;
   localparam logic [7:0] OP_OR   = 8'h0A;
   localparam logic [7:0] OP_XOR  = 8'h0B;
   localparam logic [7:0] OP_JMP  = 8'h31;
   localparam logic [7:0] OP_JZ   = 8'h32;
   localparam logic [7:0] OP_JP   = 8'h33;
   localparam logic [7:0] OP_JN   = 8'h34;
   localparam logic [7:0] OP_JNZ  = 8'h35;
   localparam logic [7:0] OP_JNP  = 8'h36;
   localparam logic [7:0] OP_JNN  = 8'h37;
   localparam logic [7:0] OP_LDL  = 8'h38;
   localparam logic [7:0] OP_LDH  = 8'h39;
   localparam logic [7:0] OP_NOT  = 8'h3B;
   localparam logic [7:0] OP_STOP = 8'hF0;

   // Operand kinds.
   localparam logic [1:0] T_MEM  = 2'd0;
   localparam logic [1:0] T_IMM  = 2'd1;
   localparam logic [1:0] T_REG  = 2'd2;
   localparam logic [1:0] T_NONE = 2'd3;

   // Register parts.
   localparam logic [1:0] SEG_ALL = 2'd0;
   localparam logic [1:0] SEG_B0  = 2'd1;
   localparam logic [1:0] SEG_B1  = 2'd2;
   localparam logic [1:0] SEG_H   = 2'd3;

   // Status codes.
   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_STOP = 3'd1;
   localparam logic [2:0] ST_SEG  = 3'd2;
   localparam logic [2:0] ST_DIVZ = 3'd3;
   localparam logic [2:0] ST_IMM  = 3'd4;

   // Register file read selects.
   localparam logic [1:0] RS_K  = 2'd0;
   localparam logic [1:0] RS_W  = 2'd1;
   localparam logic [1:0] RS_RB = 2'd2;

   // Write-back steps, in the order they take effect.
   localparam logic [2:0] WS_IP = 3'd0;
   localparam logic [2:0] WS_AC = 3'd1;
   localparam logic [2:0] WS_A  = 3'd2;
   localparam logic [2:0] WS_B  = 3'd3;
   localparam logic [2:0] WS_CC = 3'd4;

   typedef struct packed {
      logic              operation;
      logic [7:0]        opcode;
      logic [1:0]        a_type;
      logic [3:0]        a_reg;
      logic [1:0]        a_seg;
      logic signed [15:0] a_disp;
      logic [1:0]        b_type;
      logic [3:0]        b_reg;
      logic [1:0]        b_seg;
      logic signed [15:0] b_disp;
      logic [13:0]       load_address;
      logic [7:0]        load_byte;
   } req_item_type;

   typedef struct packed {
      logic [15:0]        next_ip;
      logic signed [31:0] result_value;
      logic               cond_zero;
      logic               cond_negative;
      logic [2:0]         status;
   } rsp_item_type;

   typedef struct packed {
      logic       clr;
      logic       capture;
      logic       pre_wr;
      logic       cap_k;
      logic       cap_rb;
      logic       addr_calc;
      logic       lat_a;
      logic       lat_b;
      logic       mrd_a;
      logic       mrd_b;
      logic       set_st;
      logic [2:0] st_code;
      logic       div_start;
      logic       alu;
      logic       w_calc;
      logic       w_reg;
      logic       w_mem;
      logic       out_load;
      logic [1:0] rf_rsel;
      logic [2:0] wsel;
      logic [2:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic       clr_done;
      logic       pre;
      logic       need_a;
      logic       need_b;
      logic       a_mem;
      logic       b_mem;
      logic       a_ok;
      logic       b_ok;
      logic       mra_last;
      logic       mrb_last;
      logic       div_zero;
      logic       is_div;
      logic       is_stop;
      logic [2:0] dst_code;
      logic       div_done;
      logic       w_en;
      logic       w_mem;
      logic       w_ok;
      logic       w_last;
   } stat_type;

   function automatic logic [1:0] op_len(input logic [1:0] kind);
      logic [1:0] n;
      case (kind)
         T_MEM:   n = 2'd3;
         T_IMM:   n = 2'd2;
         T_REG:   n = 2'd1;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [2:0] mem_size(input logic [1:0] seg);
      logic [2:0] n;
      case (seg)
         SEG_ALL: n = 3'd4;
         SEG_B1:  n = 3'd2;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

### rtl/rvm_req_if.sv
// ----------------------------------------------------------------------------
// rvm_req_if
// Request channel: one decoded instruction or one preload byte per beat.
// ----------------------------------------------------------------------------
interface rvm_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [7:0]         opcode;
   logic [1:0]         a_type;
   logic [3:0]         a_reg;
   logic [1:0]         a_seg;
   logic signed [15:0] a_disp;
   logic [1:0]         b_type;
   logic [3:0]         b_reg;
   logic [1:0]         b_seg;
   logic signed [15:0] b_disp;
   logic [13:0]        load_address;
   logic [7:0]         load_byte;

   modport source (
      output valid, operation, opcode, a_type, a_reg, a_seg, a_disp,
             b_type, b_reg, b_seg, b_disp, load_address, load_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, opcode, a_type, a_reg, a_seg, a_disp,
             b_type, b_reg, b_seg, b_disp, load_address, load_byte,
      output ready
   );
endinterface

### rtl/rvm_rsp_if.sv
// ----------------------------------------------------------------------------
// rvm_rsp_if
// Response channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface rvm_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        next_ip;
   logic signed [31:0] result_value;
   logic               cond_zero;
   logic               cond_negative;
   logic [2:0]         status;

   modport source (
      output valid, next_ip, result_value, cond_zero, cond_negative, status,
      input  ready
   );
   modport sink (
      input  valid, next_ip, result_value, cond_zero, cond_negative, status,
      output ready
   );
endinterface

### rtl/rvm_div.sv
// ----------------------------------------------------------------------------
// rvm_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rvm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quot,
   output logic [31:0] rem
);
   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [32:0] r_ff;
   logic [31:0] q_ff;
   logic [31:0] d_ff;
   logic        neg_q_ff;
   logic        neg_r_ff;
   logic [32:0] r_shift;
   logic [32:0] r_diff;

   assign r_shift = {r_ff[31:0], q_ff[31]};
   assign r_diff  = r_shift - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff     <= '0;
         q_ff     <= dividend[31] ? (32'd0 - dividend) : dividend;
         d_ff     <= divisor[31] ? (32'd0 - divisor) : divisor;
         neg_q_ff <= dividend[31] ^ divisor[31];
         neg_r_ff <= dividend[31];
      end else if (busy_ff) begin
         if (!r_diff[32]) begin
            r_ff <= r_diff;
            q_ff <= {q_ff[30:0], 1'b1};
         end else begin
            r_ff <= r_shift;
            q_ff <= {q_ff[30:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quot = neg_q_ff ? (32'd0 - q_ff) : q_ff;
   assign rem  = neg_r_ff ? (32'd0 - r_ff[31:0]) : r_ff[31:0];
endmodule

### rtl/rvm_dp.sv
// ----------------------------------------------------------------------------
// rvm_dp
// Datapath: register file, data memory, operand and result registers, ALU,
// address checks and the divider.
// ----------------------------------------------------------------------------
module rvm_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rvm_pkg::cmd_type      cmd,
   output rvm_pkg::stat_type     stat,
   input  rvm_pkg::req_item_type in_item,
   output rvm_pkg::rsp_item_type out_item,
   input  logic                 csr_wr_en,
   input  logic [13:0]          csr_wr_data
);
   localparam int AW = rvm_pkg::MEM_AW;
   localparam int RW = rvm_pkg::REG_AW;

   logic [31:0] rf_mem [rvm_pkg::NUM_REGS];
   logic [7:0]  dm_mem [rvm_pkg::MEM_BYTES];

   logic [13:0]           base_ff;
   logic [AW-1:0]         clr_cnt_ff;
   rvm_pkg::req_item_type item_ff;
   rvm_pkg::rsp_item_type out_ff;
   logic [2:0]  st_ff;
   logic [31:0] ip_ff, cc_ff, ac_ff, ra_ff, rb_ff;
   logic [31:0] va_ff, vb_ff, res_ff, rem_ff;
   logic [AW-1:0] a_addr_ff, b_addr_ff;
   logic          a_ok_ff, b_ok_ff;
   logic [AW-1:0] w_addr_ff;
   logic [31:0] rf_rd_ff;
   logic [7:0]  dm_rd_ff;

   logic [7:0]  opc;
   logic        two, is_ldx, take, wa, setcc;
   logic [2:0]  len;
   logic [AW:0] a_calc, b_calc, w_calc;
   logic [31:0] alu_res;
   logic [63:0] prod;
   logic [31:0] div_q, div_r;
   logic        div_done;
   logic [2:0]  dst;

   logic [RW-1:0] t_reg;
   logic [1:0]    t_seg;
   logic          t_mem;
   logic [15:0]   t_disp;
   logic [31:0]   t_val;
   logic          t_en;
   logic [2:0]    t_n;
   logic [2:0]    t_idx;
   logic [7:0]    t_byte;

   logic [RW-1:0] rf_raddr, rf_waddr;
   logic [31:0]   rf_wdata;
   logic          rf_we;
   logic [AW-1:0] dm_raddr, dm_waddr;
   logic [7:0]    dm_wdata;
   logic          dm_we;
   logic [31:0]   la32;

   function automatic logic [31:0] rpart(input logic [31:0] r, input logic [1:0] seg);
      logic [31:0] v;
      case (seg)
         rvm_pkg::SEG_ALL: v = r;
         rvm_pkg::SEG_B0:  v = {{24{r[7]}}, r[7:0]};
         rvm_pkg::SEG_B1:  v = {{24{r[15]}}, r[15:8]};
         default:          v = {{16{r[15]}}, r[15:0]};
      endcase
      return v;
   endfunction

   function automatic logic [31:0] merge(input logic [31:0] old, input logic [1:0] seg,
                                         input logic [31:0] v);
      logic [31:0] m;
      case (seg)
         rvm_pkg::SEG_ALL: m = v;
         rvm_pkg::SEG_B0:  m = {old[31:8], v[7:0]};
         rvm_pkg::SEG_B1:  m = {old[31:16], v[7:0], old[7:0]};
         default:          m = {old[31:16], v[15:0]};
      endcase
      return m;
   endfunction

   function automatic logic [31:0] opval(input logic [1:0] kind, input logic [31:0] r,
                                         input logic [1:0] seg, input logic [15:0] disp);
      logic [31:0] v;
      case (kind)
         rvm_pkg::T_REG: v = rpart(r, seg);
         rvm_pkg::T_IMM: v = {{16{disp[15]}}, disp};
         default:        v = 32'd0;
      endcase
      return v;
   endfunction

   // Returns {in_bounds, byte_address}.
   function automatic logic [AW:0] calc_addr(input logic [13:0] base, input logic [31:0] r,
                                             input logic [15:0] disp, input logic [1:0] seg);
      logic signed [33:0] s;
      logic signed [33:0] b;
      logic               ok;
      b  = $signed({20'd0, base});
      s  = b + $signed({{2{r[31]}}, r}) + $signed({{18{disp[15]}}, disp});
      ok = (s >= b) && (s < $signed(34'(rvm_pkg::MEM_BYTES - 1))) &&
           ((s + $signed({31'd0, rvm_pkg::mem_size(seg)})) <=
            $signed(34'(rvm_pkg::MEM_BYTES)));
      return {ok, s[AW-1:0]};
   endfunction

   // Decode of the held instruction.
   assign opc    = item_ff.opcode;
   assign two    = (opc <= rvm_pkg::OP_XOR);
   assign is_ldx = (opc == rvm_pkg::OP_LDL) || (opc == rvm_pkg::OP_LDH);
   assign wa     = (two && (opc != rvm_pkg::OP_CMP)) || (opc == rvm_pkg::OP_NOT);
   assign len    = 3'd1 + {1'b0, rvm_pkg::op_len(item_ff.a_type)} +
                   {1'b0, rvm_pkg::op_len(item_ff.b_type)};

   always_comb begin
      case (opc)
         rvm_pkg::OP_ADD, rvm_pkg::OP_SUB, rvm_pkg::OP_MUL, rvm_pkg::OP_DIV,
         rvm_pkg::OP_CMP, rvm_pkg::OP_SHR, rvm_pkg::OP_AND, rvm_pkg::OP_OR,
         rvm_pkg::OP_XOR, rvm_pkg::OP_NOT: setcc = 1'b1;
         default:                          setcc = 1'b0;
      endcase
   end

   always_comb begin
      unique case (opc)
         rvm_pkg::OP_JMP: take = 1'b1;
         rvm_pkg::OP_JZ:  take = cc_ff[30];
         rvm_pkg::OP_JP:  take = !cc_ff[30] && !cc_ff[31];
         rvm_pkg::OP_JN:  take = cc_ff[31];
         rvm_pkg::OP_JNZ: take = !cc_ff[30];
         rvm_pkg::OP_JNP: take = cc_ff[30] || cc_ff[31];
         rvm_pkg::OP_JNN: take = !cc_ff[31];
         default:         take = 1'b0;
      endcase
   end

   // Destination check: immediate or none is a write fault, memory must be in bounds.
   always_comb begin
      dst = rvm_pkg::ST_OK;
      if (wa) begin
         if (item_ff.a_type == rvm_pkg::T_MEM) begin
            dst = a_ok_ff ? rvm_pkg::ST_OK : rvm_pkg::ST_SEG;
         end else if (item_ff.a_type != rvm_pkg::T_REG) begin
            dst = rvm_pkg::ST_IMM;
         end
         if (dst == rvm_pkg::ST_OK && opc == rvm_pkg::OP_SWAP) begin
            if (item_ff.b_type == rvm_pkg::T_MEM) begin
               dst = b_ok_ff ? rvm_pkg::ST_OK : rvm_pkg::ST_SEG;
            end else if (item_ff.b_type != rvm_pkg::T_REG) begin
               dst = rvm_pkg::ST_IMM;
            end
         end
      end
   end

   assign a_calc = calc_addr(base_ff, ra_ff, item_ff.a_disp, item_ff.a_seg);
   assign b_calc = calc_addr(base_ff, rb_ff, item_ff.b_disp, item_ff.b_seg);

   // A memory store forms its address again from the base register as it is
   // after the earlier write-back steps, which may have moved it.
   assign w_calc = calc_addr(base_ff, rf_rd_ff, t_disp, t_seg);

   assign prod = va_ff * vb_ff;

   always_comb begin
      case (opc)
         rvm_pkg::OP_MOV:  alu_res = vb_ff;
         rvm_pkg::OP_ADD:  alu_res = va_ff + vb_ff;
         rvm_pkg::OP_SUB:  alu_res = va_ff - vb_ff;
         rvm_pkg::OP_SWAP: alu_res = vb_ff;
         rvm_pkg::OP_MUL:  alu_res = prod[31:0];
         rvm_pkg::OP_DIV:  alu_res = div_q;
         rvm_pkg::OP_CMP:  alu_res = va_ff - vb_ff;
         rvm_pkg::OP_SHL:  alu_res = (|vb_ff[31:5]) ? 32'd0 : (va_ff << vb_ff[4:0]);
         rvm_pkg::OP_SHR:  alu_res = (|vb_ff[31:5]) ? {32{va_ff[31]}} :
                                     32'($signed(va_ff) >>> vb_ff[4:0]);
         rvm_pkg::OP_AND:  alu_res = va_ff & vb_ff;
         rvm_pkg::OP_OR:   alu_res = va_ff | vb_ff;
         rvm_pkg::OP_XOR:  alu_res = va_ff ^ vb_ff;
         rvm_pkg::OP_LDL:  alu_res = {ac_ff[31:16], va_ff[15:0]};
         rvm_pkg::OP_LDH:  alu_res = {va_ff[15:0], ac_ff[15:0]};
         rvm_pkg::OP_NOT:  alu_res = ~va_ff;
         default:          alu_res = 32'd0;
      endcase
   end

   // Write-back target of the current step.
   always_comb begin
      t_reg  = rvm_pkg::REG_IP;
      t_seg  = rvm_pkg::SEG_ALL;
      t_mem  = 1'b0;
      t_disp = item_ff.a_disp;
      t_val  = 32'd0;
      t_en   = 1'b0;
      case (cmd.wsel)
         rvm_pkg::WS_IP: begin
            t_en  = 1'b1;
            t_val = (st_ff != rvm_pkg::ST_OK) ? {18'd0, base_ff} :
                    take ? va_ff : (ip_ff + {29'd0, len});
         end
         rvm_pkg::WS_AC: begin
            t_reg = rvm_pkg::REG_AC;
            t_en  = (st_ff == rvm_pkg::ST_OK) && ((opc == rvm_pkg::OP_DIV) || is_ldx);
            t_val = (opc == rvm_pkg::OP_DIV) ? rem_ff : res_ff;
         end
         rvm_pkg::WS_A: begin
            t_reg = item_ff.a_reg;
            t_seg = item_ff.a_seg;
            t_mem = (item_ff.a_type == rvm_pkg::T_MEM);
            t_en  = (st_ff == rvm_pkg::ST_OK) && wa;
            t_val = res_ff;
         end
         rvm_pkg::WS_B: begin
            t_reg  = item_ff.b_reg;
            t_seg  = item_ff.b_seg;
            t_mem  = (item_ff.b_type == rvm_pkg::T_MEM);
            t_disp = item_ff.b_disp;
            t_en   = (st_ff == rvm_pkg::ST_OK) && (opc == rvm_pkg::OP_SWAP);
            t_val  = va_ff;
         end
         rvm_pkg::WS_CC: begin
            t_reg = rvm_pkg::REG_CC;
            t_en  = (st_ff == rvm_pkg::ST_OK) && setcc;
            t_val = (res_ff == 32'd0) ? rvm_pkg::CC_ZERO :
                    res_ff[31] ? rvm_pkg::CC_NEG : 32'd0;
         end
         default: t_en = 1'b0;
      endcase
   end

   // Memory stores go most significant byte first.
   assign t_n   = rvm_pkg::mem_size(t_seg);
   assign t_idx = t_n - 3'd1 - cmd.cnt;
   always_comb begin
      case (t_idx[1:0])
         2'd0:    t_byte = t_val[7:0];
         2'd1:    t_byte = t_val[15:8];
         2'd2:    t_byte = t_val[23:16];
         default: t_byte = t_val[31:24];
      endcase
   end

   // Register file ports.
   always_comb begin
      case (cmd.rf_rsel)
         rvm_pkg::RS_K: begin
            case (cmd.cnt)
               3'd0:    rf_raddr = rvm_pkg::REG_IP;
               3'd1:    rf_raddr = rvm_pkg::REG_CC;
               3'd2:    rf_raddr = rvm_pkg::REG_AC;
               3'd3:    rf_raddr = item_ff.a_reg;
               default: rf_raddr = item_ff.b_reg;
            endcase
         end
         rvm_pkg::RS_W:  rf_raddr = t_reg;
         rvm_pkg::RS_RB: rf_raddr = (cmd.cnt == 3'd0) ? rvm_pkg::REG_IP : rvm_pkg::REG_CC;
         default:        rf_raddr = rvm_pkg::REG_IP;
      endcase
   end

   assign rf_we    = cmd.clr || cmd.w_reg;
   assign rf_waddr = cmd.clr ? clr_cnt_ff[RW-1:0] : t_reg;
   assign rf_wdata = cmd.clr ? 32'd0 : merge(rf_rd_ff, t_seg, t_val);

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      rf_rd_ff <= rf_mem[rf_raddr];
   end

   // Data memory ports.
   assign la32     = {18'd0, item_ff.load_address};
   assign dm_raddr = (cmd.mrd_b ? b_addr_ff : a_addr_ff) + AW'(cmd.cnt);
   always_comb begin
      dm_we    = 1'b0;
      dm_waddr = clr_cnt_ff;
      dm_wdata = 8'd0;
      if (cmd.clr) begin
         dm_we = 1'b1;
      end else if (cmd.pre_wr) begin
         dm_we    = (la32 < 32'(rvm_pkg::MEM_BYTES));
         dm_waddr = la32[AW-1:0];
         dm_wdata = item_ff.load_byte;
      end else if (cmd.w_mem) begin
         dm_we    = 1'b1;
         dm_waddr = w_addr_ff + AW'(cmd.cnt);
         dm_wdata = t_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[dm_waddr] <= dm_wdata;
      end
      dm_rd_ff <= dm_mem[dm_raddr];
   end

   // Control-side registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         if (cmd.clr) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= in_item;
         st_ff   <= rvm_pkg::ST_OK;
         va_ff   <= '0;
         vb_ff   <= '0;
         res_ff  <= '0;
      end
      if (cmd.cap_k) begin
         case (cmd.cnt)
            3'd1:    ip_ff <= rf_rd_ff;
            3'd2:    cc_ff <= rf_rd_ff;
            3'd3:    ac_ff <= rf_rd_ff;
            3'd4:    ra_ff <= rf_rd_ff;
            3'd5:    rb_ff <= rf_rd_ff;
            default: ;
         endcase
      end
      if (cmd.cap_rb) begin
         if (cmd.cnt == 3'd1) ip_ff <= rf_rd_ff;
         if (cmd.cnt == 3'd2) cc_ff <= rf_rd_ff;
      end
      if (cmd.addr_calc) begin
         a_ok_ff   <= a_calc[AW];
         a_addr_ff <= a_calc[AW-1:0];
         b_ok_ff   <= b_calc[AW];
         b_addr_ff <= b_calc[AW-1:0];
      end
      if (cmd.w_calc) begin
         w_addr_ff <= w_calc[AW-1:0];
      end
      if (cmd.lat_a) begin
         va_ff <= opval(item_ff.a_type, ra_ff, item_ff.a_seg, item_ff.a_disp);
      end
      if (cmd.lat_b) begin
         vb_ff <= opval(item_ff.b_type, rb_ff, item_ff.b_seg, item_ff.b_disp);
      end
      if (cmd.mrd_a && cmd.cnt != 3'd0) begin
         va_ff <= {va_ff[23:0], dm_rd_ff};
      end
      if (cmd.mrd_b && cmd.cnt != 3'd0) begin
         vb_ff <= {vb_ff[23:0], dm_rd_ff};
      end
      if (cmd.set_st) begin
         st_ff <= cmd.st_code;
      end
      if (cmd.alu) begin
         res_ff <= alu_res;
         rem_ff <= div_r;
      end
      if (cmd.out_load) begin
         out_ff.next_ip       <= ip_ff[15:0];
         out_ff.result_value  <= (!item_ff.operation && st_ff == rvm_pkg::ST_OK &&
                                  (wa || is_ldx)) ? res_ff : 32'd0;
         out_ff.cond_zero     <= cc_ff[30];
         out_ff.cond_negative <= cc_ff[31];
         out_ff.status        <= st_ff;
      end
   end

   rvm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (va_ff),
      .divisor  (vb_ff),
      .done     (div_done),
      .quot     (div_q),
      .rem      (div_r)
   );

   assign out_item = out_ff;

   always_comb begin
      stat          = '0;
      stat.clr_done = (clr_cnt_ff == AW'(rvm_pkg::MEM_BYTES - 1));
      stat.pre      = item_ff.operation;
      stat.need_a   = (two && opc != rvm_pkg::OP_MOV) || take || is_ldx ||
                      (opc == rvm_pkg::OP_NOT);
      stat.need_b   = two;
      stat.a_mem    = (item_ff.a_type == rvm_pkg::T_MEM);
      stat.b_mem    = (item_ff.b_type == rvm_pkg::T_MEM);
      stat.a_ok     = a_ok_ff;
      stat.b_ok     = b_ok_ff;
      stat.mra_last = (cmd.cnt == rvm_pkg::mem_size(item_ff.a_seg));
      stat.mrb_last = (cmd.cnt == rvm_pkg::mem_size(item_ff.b_seg));
      stat.is_div   = (opc == rvm_pkg::OP_DIV);
      stat.div_zero = (opc == rvm_pkg::OP_DIV) && (vb_ff == 32'd0);
      stat.is_stop  = (opc == rvm_pkg::OP_STOP);
      stat.dst_code = dst;
      stat.div_done = div_done;
      stat.w_en     = t_en;
      stat.w_mem    = t_mem;
      stat.w_ok     = w_calc[AW];
      stat.w_last   = (cmd.cnt == t_n - 3'd1);
   end
endmodule

### rtl/rvm_ctrl.sv
// ----------------------------------------------------------------------------
// rvm_ctrl
// Sequencer: steps the datapath through clearing, preload writes, operand fetch,
// checks, execution, ordered write-back and result hand-off.
// ----------------------------------------------------------------------------
module rvm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rvm_pkg::cmd_type  cmd,
   input  rvm_pkg::stat_type stat
);
   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_RREG = 5'd2;
   localparam logic [4:0] S_PRE  = 5'd3;
   localparam logic [4:0] S_ADDR = 5'd4;
   localparam logic [4:0] S_OPA  = 5'd5;
   localparam logic [4:0] S_MRA  = 5'd6;
   localparam logic [4:0] S_OPB  = 5'd7;
   localparam logic [4:0] S_MRB  = 5'd8;
   localparam logic [4:0] S_CHK  = 5'd9;
   localparam logic [4:0] S_DIV  = 5'd10;
   localparam logic [4:0] S_ALU  = 5'd11;
   localparam logic [4:0] S_WSEL = 5'd12;
   localparam logic [4:0] S_WREG = 5'd13;
   localparam logic [4:0] S_WMEM = 5'd14;
   localparam logic [4:0] S_RB   = 5'd15;
   localparam logic [4:0] S_DONE = 5'd16;
   localparam logic [4:0] S_WADR = 5'd17;

   logic [4:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] wsel_ff, wsel_in;
   logic       rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      wsel_in     = wsel_ff;
      cmd         = '0;
      cmd.cnt     = cnt_ff;
      cmd.wsel    = wsel_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               state_in    = S_RREG;
            end
         end
         S_RREG: begin
            cmd.rf_rsel = rvm_pkg::RS_K;
            cmd.cap_k   = 1'b1;
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               cnt_in   = '0;
               state_in = stat.pre ? S_PRE : S_ADDR;
            end
         end
         S_PRE: begin
            cmd.pre_wr = 1'b1;
            cnt_in     = '0;
            state_in   = S_RB;
         end
         S_ADDR: begin
            cmd.addr_calc = 1'b1;
            state_in      = S_OPA;
         end
         S_OPA: begin
            state_in = S_OPB;
            if (stat.need_a) begin
               cmd.lat_a = 1'b1;
               if (stat.a_mem) begin
                  cnt_in = '0;
                  if (!stat.a_ok) begin
                     cmd.set_st  = 1'b1;
                     cmd.st_code = rvm_pkg::ST_SEG;
                     wsel_in     = rvm_pkg::WS_IP;
                     state_in    = S_WSEL;
                  end else begin
                     state_in = S_MRA;
                  end
               end
            end
         end
         S_MRA: begin
            cmd.mrd_a = 1'b1;
            cnt_in    = cnt_ff + 3'd1;
            if (stat.mra_last) state_in = S_OPB;
         end
         S_OPB: begin
            state_in = S_CHK;
            if (stat.need_b) begin
               cmd.lat_b = 1'b1;
               if (stat.b_mem) begin
                  cnt_in = '0;
                  if (!stat.b_ok) begin
                     cmd.set_st  = 1'b1;
                     cmd.st_code = rvm_pkg::ST_SEG;
                     wsel_in     = rvm_pkg::WS_IP;
                     state_in    = S_WSEL;
                  end else begin
                     state_in = S_MRB;
                  end
               end
            end
         end
         S_MRB: begin
            cmd.mrd_b = 1'b1;
            cnt_in    = cnt_ff + 3'd1;
            if (stat.mrb_last) state_in = S_CHK;
         end
         S_CHK: begin
            wsel_in = rvm_pkg::WS_IP;
            cnt_in  = '0;
            if (stat.div_zero) begin
               cmd.set_st  = 1'b1;
               cmd.st_code = rvm_pkg::ST_DIVZ;
               state_in    = S_WSEL;
            end else if (stat.dst_code != rvm_pkg::ST_OK) begin
               cmd.set_st  = 1'b1;
               cmd.st_code = stat.dst_code;
               state_in    = S_WSEL;
            end else if (stat.is_stop) begin
               cmd.set_st  = 1'b1;
               cmd.st_code = rvm_pkg::ST_STOP;
               state_in    = S_WSEL;
            end else if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_ALU;
            end
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_ALU;
         end
         S_ALU: begin
            cmd.alu  = 1'b1;
            wsel_in  = rvm_pkg::WS_IP;
            cnt_in   = '0;
            state_in = S_WSEL;
         end
         S_WSEL: begin
            cmd.rf_rsel = rvm_pkg::RS_W;
            cnt_in      = '0;
            if (!stat.w_en) begin
               if (wsel_ff == rvm_pkg::WS_CC) begin
                  state_in = S_RB;
               end else begin
                  wsel_in = wsel_ff + 3'd1;
               end
            end else if (stat.w_mem) begin
               state_in = S_WADR;
            end else begin
               state_in = S_WREG;
            end
         end
         S_WADR: begin
            // The base register was read in the step before; a store whose
            // address now falls out of bounds is dropped.
            cnt_in = '0;
            if (stat.w_ok) begin
               cmd.w_calc = 1'b1;
               state_in   = S_WMEM;
            end else if (wsel_ff == rvm_pkg::WS_CC) begin
               state_in = S_RB;
            end else begin
               wsel_in  = wsel_ff + 3'd1;
               state_in = S_WSEL;
            end
         end
         S_WREG: begin
            cmd.w_reg = 1'b1;
            cnt_in    = '0;
            if (wsel_ff == rvm_pkg::WS_CC) begin
               state_in = S_RB;
            end else begin
               wsel_in  = wsel_ff + 3'd1;
               state_in = S_WSEL;
            end
         end
         S_WMEM: begin
            cmd.w_mem = 1'b1;
            cnt_in    = cnt_ff + 3'd1;
            if (stat.w_last) begin
               cnt_in = '0;
               if (wsel_ff == rvm_pkg::WS_CC) begin
                  state_in = S_RB;
               end else begin
                  wsel_in  = wsel_ff + 3'd1;
                  state_in = S_WSEL;
               end
            end
         end
         S_RB: begin
            cmd.rf_rsel = rvm_pkg::RS_RB;
            cmd.cap_rb  = 1'b1;
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == 3'd2) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         cnt_ff       <= '0;
         wsel_ff      <= rvm_pkg::WS_IP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         wsel_ff  <= wsel_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### rtl/register_memory_vm_execute_unit.sv
// ----------------------------------------------------------------------------
// register_memory_vm_execute_unit
// Executes one decoded instruction of a small register-memory VM per request
// beat, or preloads one data memory byte, and returns one response beat.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      carries
//   req_if    in         valid/ready    operation, opcode, operands, preload
//   rsp_if    out        valid/ready    next_ip, result_value, flags, status
//   csr       in         csr_wr_en      data_segment_base (14 bits)
//
// After reset the unit sweeps the data memory and register file to zero, one
// entry per cycle, over all MEM_BYTES (16384) addresses; no request beat is
// taken until the sweep ends, though csr writes are accepted during it.
// A preload reads the registers, writes its byte and reads IP and CC back. An
// instruction reads IP, CC, AC, both operand registers and each memory operand
// byte, then does a read-modify-write pair per register write-back and, for a
// memory store, an address step plus a write per byte, all through the single
// port of the register file and of the data memory. Divide also waits on the
// bit-serial divider. A response waits in its output register while the next
// request beat is accepted; only the hand-off of the next result stalls.
//
module register_memory_vm_execute_unit (
   input  logic        clock,
   input  logic        reset,
   rvm_req_if.sink     req_if,
   rvm_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [13:0] csr_wr_data
);
   rvm_pkg::cmd_type      cmd;
   rvm_pkg::stat_type     stat;
   rvm_pkg::req_item_type in_item;
   rvm_pkg::rsp_item_type out_item;

   // Gather the request fields into one item for the datapath.
   assign in_item.operation    = req_if.operation;
   assign in_item.opcode       = req_if.opcode;
   assign in_item.a_type       = req_if.a_type;
   assign in_item.a_reg        = req_if.a_reg;
   assign in_item.a_seg        = req_if.a_seg;
   assign in_item.a_disp       = req_if.a_disp;
   assign in_item.b_type       = req_if.b_type;
   assign in_item.b_reg        = req_if.b_reg;
   assign in_item.b_seg        = req_if.b_seg;
   assign in_item.b_disp       = req_if.b_disp;
   assign in_item.load_address = req_if.load_address;
   assign in_item.load_byte    = req_if.load_byte;

   // The sequencer owns both handshakes.
   rvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds all architectural state and the output register.
   rvm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_item     (in_item),
      .out_item    (out_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   assign rsp_if.next_ip       = out_item.next_ip;
   assign rsp_if.result_value  = out_item.result_value;
   assign rsp_if.cond_zero     = out_item.cond_zero;
   assign rsp_if.cond_negative = out_item.cond_negative;
   assign rsp_if.status        = out_item.status;
endmodule

### dv/rvm_exec_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rvm_exec_checker
// Watches the request and response channels of the VM execute unit, predicts
// every response beat from a private copy of registers, memory and segment
// base, and compares the response beats field by field in order.
// ----------------------------------------------------------------------------
module rvm_exec_checker
   import rvm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rvm_req_if.sink     req_mon,
   rvm_rsp_if.sink     rsp_mon,
   input  logic        csr_wr_en,
   input  logic [13:0] csr_wr_data,
   output int          fail_count,
   output int          pending_count
);

   logic [31:0]  vm_regs [NUM_REGS];
   logic [7:0]   vm_mem  [MEM_BYTES];
   logic [13:0]  seg_base;
   rsp_item_type expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic logic [31:0] sx8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

   // Forms the operand address; returns 0 when it is out of bounds.
   function automatic bit operand_addr(input logic [3:0] r, input logic [1:0] seg,
                                       input logic signed [15:0] disp,
                                       output longint addr);
      longint sum;
      sum = longint'(seg_base) + longint'($signed(vm_regs[r])) + longint'(disp);
      addr = sum;
      return !(sum < longint'(seg_base) || sum >= MEM_BYTES - 1 ||
               sum + longint'(mem_size(seg)) > MEM_BYTES);
   endfunction

   function automatic logic [2:0] fetch_operand(input logic [1:0] kind, input logic [3:0] r,
                                                input logic [1:0] seg,
                                                input logic signed [15:0] disp,
                                                output logic [31:0] val);
      logic [31:0] rv;
      longint      addr;
      val = '0;
      rv  = vm_regs[r];
      if (kind == T_REG) begin
         case (seg)
            SEG_ALL: val = rv;
            SEG_B0:  val = sx8(rv[7:0]);
            SEG_B1:  val = sx8(rv[15:8]);
            default: val = {{16{rv[15]}}, rv[15:0]};
         endcase
      end else if (kind == T_IMM) begin
         val = 32'(disp);
      end else if (kind == T_MEM) begin
         if (!operand_addr(r, seg, disp, addr)) return ST_SEG;
         for (int i = 0; i < mem_size(seg); i++) val = {val[23:0], vm_mem[addr + i]};
      end
      return ST_OK;
   endfunction

   function automatic logic [2:0] dest_status(input logic [1:0] kind, input logic [3:0] r,
                                              input logic [1:0] seg,
                                              input logic signed [15:0] disp);
      longint addr;
      if (kind == T_REG) return ST_OK;
      if (kind == T_MEM) return operand_addr(r, seg, disp, addr) ? ST_OK : ST_SEG;
      return ST_IMM;
   endfunction

   function automatic void store_operand(input logic [1:0] kind, input logic [3:0] r,
                                         input logic [1:0] seg,
                                         input logic signed [15:0] disp,
                                         input logic [31:0] v);
      longint addr;
      int     n;
      if (kind == T_REG) begin
         case (seg)
            SEG_ALL: vm_regs[r] = v;
            SEG_B0:  vm_regs[r][7:0] = v[7:0];
            SEG_B1:  vm_regs[r][15:8] = v[7:0];
            default: vm_regs[r][15:0] = v[15:0];
         endcase
      end else if (kind == T_MEM && operand_addr(r, seg, disp, addr)) begin
         n = mem_size(seg);
         for (int i = 0; i < n; i++) vm_mem[addr + i] = 8'(v >> (8 * (n - 1 - i)));
      end
   endfunction

   function automatic logic [31:0] cc_for(input logic [31:0] v);
      return (v == 0) ? CC_ZERO : (v[31] ? CC_NEG : 32'h0);
   endfunction

   // Applies one request beat to the private machine state and returns the
   // response it must produce.
   function automatic rsp_item_type execute_beat(input req_item_type q);
      rsp_item_type o;
      logic [31:0]  va, vb, res, rem, ip_next, ccv;
      logic [2:0]   st;
      logic [7:0]   opc;
      bit           two, take, wa, wb, setcc, wrem;
      longint       sa, sb;
      va = 0; vb = 0; res = 0; rem = 0; st = ST_OK;
      take = 0; wa = 0; wb = 0; setcc = 0; wrem = 0;
      opc = q.opcode;
      if (q.operation) begin
         vm_mem[q.load_address] = q.load_byte;
      end else begin
         ip_next = vm_regs[REG_IP] + 1 + op_len(q.a_type) + op_len(q.b_type);
         ccv = vm_regs[REG_CC];
         two = opc <= OP_XOR;
         case (opc)
            OP_JMP:  take = 1;
            OP_JZ:   take = ccv[30];
            OP_JP:   take = !ccv[30] && !ccv[31];
            OP_JN:   take = ccv[31];
            OP_JNZ:  take = !ccv[30];
            OP_JNP:  take = ccv[30] || ccv[31];
            OP_JNN:  take = !ccv[31];
            default: take = 0;
         endcase
         if ((two && opc != OP_MOV) || take || opc == OP_LDL || opc == OP_LDH ||
             opc == OP_NOT)
            st = fetch_operand(q.a_type, q.a_reg, q.a_seg, q.a_disp, va);
         if (two && st == ST_OK)
            st = fetch_operand(q.b_type, q.b_reg, q.b_seg, q.b_disp, vb);
         if (st == ST_OK && opc == OP_DIV && vb == 0) st = ST_DIVZ;
         if (st == ST_OK && ((two && opc != OP_CMP) || opc == OP_NOT)) begin
            st = dest_status(q.a_type, q.a_reg, q.a_seg, q.a_disp);
            if (st == ST_OK && opc == OP_SWAP)
               st = dest_status(q.b_type, q.b_reg, q.b_seg, q.b_disp);
         end
         if (st == ST_OK) begin
            wa = two && opc != OP_CMP;
            case (opc)
               OP_MOV:  res = vb;
               OP_ADD:  begin res = va + vb; setcc = 1; end
               OP_SUB:  begin res = va - vb; setcc = 1; end
               OP_SWAP: begin res = vb; wb = 1; end
               OP_MUL:  begin res = va * vb; setcc = 1; end
               OP_DIV:  begin
                  sa = $signed(va); sb = $signed(vb);
                  res = 32'(sa / sb); rem = 32'(sa % sb);
                  wrem = 1; setcc = 1;
               end
               OP_CMP:  begin res = va - vb; setcc = 1; end
               OP_SHL:  res = (vb >= 32) ? 0 : va << vb[4:0];
               OP_SHR:  begin
                  res = (vb >= 32) ? {32{va[31]}} : 32'($signed(va) >>> vb[4:0]);
                  setcc = 1;
               end
               OP_AND:  begin res = va & vb; setcc = 1; end
               OP_OR:   begin res = va | vb; setcc = 1; end
               OP_XOR:  begin res = va ^ vb; setcc = 1; end
               OP_LDL:  res = {vm_regs[REG_AC][31:16], va[15:0]};
               OP_LDH:  res = {va[15:0], vm_regs[REG_AC][15:0]};
               OP_NOT:  begin res = ~va; wa = 1; setcc = 1; end
               default: res = 0;
            endcase
            if (opc == OP_STOP) begin
               vm_regs[REG_IP] = 32'(seg_base);
               st = ST_STOP;
            end else begin
               vm_regs[REG_IP] = take ? va : ip_next;
               if (wrem) vm_regs[REG_AC] = rem;
               if (opc == OP_LDL || opc == OP_LDH) vm_regs[REG_AC] = res;
               if (wa) store_operand(q.a_type, q.a_reg, q.a_seg, q.a_disp, res);
               if (wb) store_operand(q.b_type, q.b_reg, q.b_seg, q.b_disp, va);
               if (setcc) vm_regs[REG_CC] = cc_for(res);
               if (!(wa || opc == OP_LDL || opc == OP_LDH)) res = 0;
            end
         end else begin
            vm_regs[REG_IP] = 32'(seg_base);
         end
         if (st != ST_OK) res = 0;
      end
      o.next_ip       = vm_regs[REG_IP][15:0];
      o.result_value  = res;
      o.cond_zero     = vm_regs[REG_CC][30];
      o.cond_negative = vm_regs[REG_CC][31];
      o.status        = st;
      return o;
   endfunction

   always @(posedge clock) begin
      req_item_type q;
      rsp_item_type got, exp_rsp;
      if (reset) begin
         foreach (vm_regs[i]) vm_regs[i] = '0;
         foreach (vm_mem[i]) vm_mem[i] = '0;
         seg_base = '0;
         fail_count <= 0;
         expected_rsps.delete();
      end else begin
         if (csr_wr_en) seg_base = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            q = '{req_mon.operation, req_mon.opcode, req_mon.a_type, req_mon.a_reg,
                  req_mon.a_seg, req_mon.a_disp, req_mon.b_type, req_mon.b_reg,
                  req_mon.b_seg, req_mon.b_disp, req_mon.load_address, req_mon.load_byte};
            expected_rsps.push_back(execute_beat(q));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.next_ip, rsp_mon.result_value, rsp_mon.cond_zero,
                    rsp_mon.cond_negative, rsp_mon.status};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (got !== exp_rsp) begin
                  $display("%0t: response mismatch: expected ip=%h res=%h z=%b n=%b st=%0d, actual ip=%h res=%h z=%b n=%b st=%0d",
                           $time, exp_rsp.next_ip, exp_rsp.result_value,
                           exp_rsp.cond_zero, exp_rsp.cond_negative, exp_rsp.status,
                           got.next_ip, got.result_value, got.cond_zero,
                           got.cond_negative, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random instruction and preload beats into the VM
// execute unit under random backpressure, changes the segment base between
// phases, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
   import rvm_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [13:0] csr_wr_data;
   int          fail_count;
   int          pending_count;

   rvm_req_if req_bus ();
   rvm_rsp_if rsp_bus ();

   register_memory_vm_execute_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus.sink),
      .rsp_if      (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rvm_exec_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus.sink),
      .rsp_mon       (rsp_bus.sink),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The unit sweeps its 16K-byte memory after reset, and every instruction runs
   // with random idle gaps on each side; this bound is several times the slowest
   // correct run.
   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   // The response side stalls a random number of cycles before each beat, and
   // for some beats does not stall at all.
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_bus.ready && rsp_bus.valid) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
               rsp_bus.ready = 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         // The beat is taken at the posedge; the next negedge decides again.
         #1;
      end
   end

   // Sends one beat, after a random idle gap, and waits until it is taken.
   task automatic send_beat(input req_item_type q);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      repeat (gap) @(negedge clock);
      {req_bus.operation, req_bus.opcode, req_bus.a_type, req_bus.a_reg, req_bus.a_seg,
       req_bus.a_disp, req_bus.b_type, req_bus.b_reg, req_bus.b_seg, req_bus.b_disp,
       req_bus.load_address, req_bus.load_byte} = q;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Waits until every predicted response beat has arrived, then lets the
   // unit settle before the segment base may change.
   task automatic drain_responses();
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_seg_base(input logic [13:0] base);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = base;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   function automatic req_item_type make_instr(input logic [7:0] opc,
                                               input logic [1:0] at, input logic [3:0] ar,
                                               input logic [1:0] as, input int ad,
                                               input logic [1:0] bt, input logic [3:0] br,
                                               input logic [1:0] bs, input int bd);
      req_item_type q;
      q = '0;
      q.opcode = opc;
      q.a_type = at; q.a_reg = ar; q.a_seg = as; q.a_disp = 16'(ad);
      q.b_type = bt; q.b_reg = br; q.b_seg = bs; q.b_disp = 16'(bd);
      q.load_address = 14'($urandom);
      q.load_byte = 8'($urandom);
      return q;
   endfunction

   function automatic req_item_type make_preload(input int addr, input logic [7:0] data);
      req_item_type q;
      q = req_item_type'({$urandom, $urandom, $urandom});
      q.operation = 1'b1;
      q.load_address = 14'(addr);
      q.load_byte = data;
      return q;
   endfunction

   // Random instruction. Most draw from the defined opcodes with memory
   // operands aimed mostly inside the segment; some are raw noise.
   function automatic req_item_type random_instr();
      logic [7:0] codes[23] = '{OP_MOV, OP_ADD, OP_SUB, OP_SWAP, OP_MUL, OP_DIV, OP_CMP,
                                OP_SHL, OP_SHR, OP_AND, OP_OR, OP_XOR, OP_JMP, OP_JZ,
                                OP_JP, OP_JN, OP_JNZ, OP_JNP, OP_JNN, OP_LDL, OP_LDH,
                                OP_NOT, OP_STOP};
      req_item_type q;
      q = req_item_type'({$urandom, $urandom, $urandom});
      q.operation = 1'b0;
      if ($urandom_range(0, 9) == 0) return q;
      q.opcode = codes[$urandom_range(0, 22)];
      q.a_type = ($urandom_range(0, 2) == 0) ? 2'($urandom) : T_REG;
      q.b_type = ($urandom_range(0, 2) == 0) ? T_REG : 2'($urandom);
      // Keep displacements mostly small so memory addresses land near the segment.
      if ($urandom_range(0, 3) != 0) begin
         if (q.a_type == T_MEM) q.a_disp = 16'($urandom_range(0, 64));
         if (q.b_type == T_MEM) q.b_disp = 16'($urandom_range(0, 64));
         if (q.b_type == T_IMM && $urandom_range(0, 1)) q.b_disp = 16'($urandom_range(0, 40));
      end
      return q;
   endfunction

   initial begin
      req_item_type q;
      logic [13:0] bases[4] = '{14'd0, 14'd16383, 14'd16000, 14'd100};
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      {req_bus.operation, req_bus.opcode, req_bus.a_type, req_bus.a_reg, req_bus.a_seg,
       req_bus.a_disp, req_bus.b_type, req_bus.b_reg, req_bus.b_seg, req_bus.b_disp,
       req_bus.load_address, req_bus.load_byte} = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: preloads at both ends of memory, every opcode but JP, JN, JNZ
      // and JNP, both faults and division by zero.
      send_beat(make_preload(0, 8'hFF));
      send_beat(make_preload(16383, 8'h80));
      send_beat(make_preload(1, 8'h01));
      send_beat(make_instr(OP_MOV, T_REG, 4'd1, SEG_ALL, 0, T_IMM, 0, 0, -32768));
      send_beat(make_instr(OP_LDH, T_IMM, 0, 0, 32767, T_NONE, 0, 0, 0));
      send_beat(make_instr(OP_LDL, T_IMM, 0, 0, -1, T_NONE, 0, 0, 0));
      send_beat(make_instr(OP_MOV, T_REG, 4'd2, SEG_ALL, 0, T_IMM, 0, 0, -1));
      send_beat(make_instr(OP_ADD, T_REG, 4'd1, SEG_ALL, 0, T_MEM, 4'd0, SEG_ALL, 0));
      send_beat(make_instr(OP_SUB, T_REG, 4'd3, SEG_B0, 0, T_REG, 4'd2, SEG_H, 0));
      send_beat(make_instr(OP_MUL, T_REG, 4'd1, SEG_B1, 0, T_IMM, 0, 0, 32767));
      send_beat(make_instr(OP_SHL, T_REG, 4'd4, SEG_ALL, 0, T_IMM, 0, 0, 31));
      send_beat(make_instr(OP_DIV, T_REG, 4'd4, SEG_ALL, 0, T_REG, 4'd2, SEG_ALL, 0));
      send_beat(make_instr(OP_DIV, T_REG, 4'd1, SEG_ALL, 0, T_IMM, 0, 0, 0));
      send_beat(make_instr(OP_SHR, T_REG, 4'd2, SEG_ALL, 0, T_IMM, 0, 0, 40));
      send_beat(make_instr(OP_CMP, T_REG, 4'd1, SEG_ALL, 0, T_REG, 4'd1, SEG_ALL, 0));
      send_beat(make_instr(OP_AND, T_MEM, 4'd0, SEG_B1, 0, T_IMM, 0, 0, -1));
      send_beat(make_instr(OP_OR, T_MEM, 4'd0, SEG_ALL, 16381, T_IMM, 0, 0, 1));
      send_beat(make_instr(OP_XOR, T_IMM, 0, 0, 5, T_IMM, 0, 0, 3));
      send_beat(make_instr(OP_SWAP, T_REG, 4'd1, SEG_ALL, 0, T_REG, 4'd2, SEG_ALL, 0));
      send_beat(make_instr(OP_NOT, T_REG, 4'd3, SEG_H, 0, T_NONE, 0, 0, 0));
      send_beat(make_instr(OP_JZ, T_IMM, 0, 0, 200, T_NONE, 0, 0, 0));
      send_beat(make_instr(OP_JNN, T_IMM, 0, 0, 300, T_NONE, 0, 0, 0));
      send_beat(make_instr(OP_JMP, T_MEM, 4'd0, SEG_ALL, -5, T_NONE, 0, 0, 0));
      send_beat(make_instr(8'h30, T_NONE, 0, 0, 0, T_NONE, 0, 0, 0));
      send_beat(make_instr(OP_STOP, T_NONE, 0, 0, 0, T_NONE, 0, 0, 0));
      drain_responses();

      // Random phases, each under its own segment base.
      for (int phase = 0; phase < 8; phase++) begin
         write_seg_base(phase < 4 ? bases[phase] : 14'($urandom));
         for (int n = 0; n < 200; n++) begin
            if ($urandom_range(0, 4) == 0)
               q = make_preload($urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 127),
                                8'($urandom));
            else
               q = random_instr();
            send_beat(q);
            // Let the unit run dry now and then with the sender held off.
            if (n == 100) while (pending_count != 0) @(negedge clock);
         end
         drain_responses();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
